/* src/assert_macros.svh */
// Assertion macros shared by the checker files of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock, off while reset is high.
`define CRMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that stays active through reset.
`define CRMM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/crmm_pkg.sv */
// Shared types and constants of the centered running min/max unit.
package crmm_pkg;

   localparam int HALF_WINDOW_W = 4;
   localparam logic [HALF_WINDOW_W-1:0] HALF_WINDOW_RESET = HALF_WINDOW_W'(1);

   // At most this many results leave for one item.
   localparam int RESULT_LIMIT = 16;
   localparam int RESULT_CNT_W = $clog2(RESULT_LIMIT);

   // Entries of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   localparam int NUM_WEDGES = 2;
   localparam int WEDGE_MAX  = 0;
   localparam int WEDGE_MIN  = 1;

   // Classification that the front attaches to each item.
   typedef struct packed {
      logic last;    // final sample of the stream
      logic rises;   // sample above the previous one: prune the max wedge
   } item_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_POP  = 4'b0010,
      ST_PUSH = 4'b0100,
      ST_SCAN = 4'b1000
   } back_state_type;

endpackage

/* src/crmm_ram.sv */
// Generic single-write, single-read RAM with registered, write-first read.
module crmm_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr_q;

   assign rd_addr_q = rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // a read of the address being written returns the new word
      if (wr_en && (wr_addr == rd_addr_q)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr_q];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/crmm_front.sv */
// Front end: accepts samples, classifies them against the previous one, queues them.
module crmm_front import crmm_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_end_of_stream,
   output logic                          q_valid,
   input  logic                          q_take,
   output logic signed [SAMPLE_BITS-1:0] q_sample,
   output item_ctrl_type                 q_ctrl
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic signed [SAMPLE_BITS-1:0] slot_sample_ff [QUEUE_DEPTH];
   item_ctrl_type                 slot_ctrl_ff [QUEUE_DEPTH];
   item_ctrl_type                 new_ctrl;
   logic                          accept;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign req_stall = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      new_ctrl.last  = req_end_of_stream;
      new_ctrl.rises = (req_sample > prev_ff);
      prev_in   = prev_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (accept) begin
         // a new stream compares its first sample against zero
         prev_in   = req_end_of_stream ? '0 : req_sample;
         wr_ptr_in = ptr_inc(wr_ptr_ff);
      end
      if (q_take) begin
         rd_ptr_in = ptr_inc(rd_ptr_ff);
      end
      fill_in = fill_ff + FILL_W'(accept) - FILL_W'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         fill_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         prev_ff   <= prev_in;
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_sample_ff[wr_ptr_ff] <= req_sample;
         slot_ctrl_ff[wr_ptr_ff]   <= new_ctrl;
      end
   end

   assign q_valid  = (fill_ff != '0);
   assign q_sample = slot_sample_ff[rd_ptr_ff];
   assign q_ctrl   = slot_ctrl_ff[rd_ptr_ff];

endmodule

/* src/crmm_back.sv */
// Back end: max and min wedges in RAM, pruning, expiry and the result register.
module crmm_back import crmm_pkg::*; #(
   parameter int MAX_HALF_WINDOW = 15,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [HALF_WINDOW_W-1:0]      half_window,
   input  logic                          q_valid,
   output logic                          q_take,
   input  logic signed [SAMPLE_BITS-1:0] q_sample,
   input  item_ctrl_type                 q_ctrl,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_max,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_min,
   output logic                          rsp_last_of_stream
);

   localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 2;
   localparam int MOD    = 4 * (MAX_HALF_WINDOW + 1);
   localparam int IDX_W  = $clog2(MOD);
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = SAMPLE_BITS + IDX_W;
   localparam int LIM_W  = IDX_W + 1;
   localparam int WCMP_W = (IDX_W > HALF_WINDOW_W) ? IDX_W : HALF_WINDOW_W;

   back_state_type state_ff, state_in;

   logic [SLOT_W-1:0] head_ff  [NUM_WEDGES];
   logic [SLOT_W-1:0] head_in  [NUM_WEDGES];
   logic [CNT_W-1:0]  count_ff [NUM_WEDGES];
   logic [CNT_W-1:0]  count_in [NUM_WEDGES];

   logic [IDX_W-1:0] in_idx_ff, in_idx_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [IDX_W-1:0] cur_idx_ff, cur_idx_in;
   logic signed [SAMPLE_BITS-1:0] cur_sample_ff, cur_sample_in;
   logic cur_last_ff, cur_last_in;
   logic sel_max_ff, sel_max_in;
   logic [RESULT_CNT_W-1:0] emitted_ff, emitted_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_min_in;
   logic rsp_last_ff, rsp_last_in;

   logic [NUM_WEDGES-1:0] wr_en;
   logic [SLOT_W-1:0]     wr_addr [NUM_WEDGES];
   logic [SLOT_W-1:0]     rd_addr [NUM_WEDGES];
   logic [WORD_W-1:0]     wr_word;
   logic [WORD_W-1:0]     rd_word [NUM_WEDGES];

   logic [WCMP_W-1:0]             hw_ext;
   logic [IDX_W-1:0]              w_idx;
   logic [IDX_W-1:0]              pend;
   logic [LIM_W-1:0]              limit;
   logic [NUM_WEDGES-1:0]         drop;
   logic [WORD_W-1:0]             sel_word;
   logic signed [SAMPLE_BITS-1:0] tail_value;
   logic [CNT_W-1:0]              sel_count;
   logic                          beats;
   logic                          out_free;
   logic                          finish;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] h,
                                                 input logic [CNT_W-1:0]  k);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(h) + (CNT_W + 1)'(k);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] dist_of(input logic [IDX_W-1:0] newer,
                                                 input logic [IDX_W-1:0] older);
      logic [IDX_W:0] d;
      if (newer >= older) begin
         d = {1'b0, newer} - {1'b0, older};
      end else begin
         d = {1'b0, newer} + (IDX_W + 1)'(MOD) - {1'b0, older};
      end
      return d[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
      return (x == IDX_W'(MOD - 1)) ? '0 : x + 1'b1;
   endfunction

   // Clamp the half width to what the wedges are sized for.
   assign hw_ext = WCMP_W'(half_window);
   assign w_idx  = (hw_ext > WCMP_W'(MAX_HALF_WINDOW)) ? IDX_W'(MAX_HALF_WINDOW)
                                                        : IDX_W'(hw_ext);

   assign pend     = dist_of(cur_idx_ff, out_idx_ff);
   assign limit    = LIM_W'(pend) + LIM_W'(w_idx);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sel_word   = sel_max_ff ? rd_word[WEDGE_MAX] : rd_word[WEDGE_MIN];
   assign tail_value = sel_word[SAMPLE_BITS-1:0];
   assign sel_count  = sel_max_ff ? count_ff[WEDGE_MAX] : count_ff[WEDGE_MIN];
   assign beats      = sel_max_ff ? (cur_sample_ff > tail_value)
                                  : (cur_sample_ff < tail_value);
   assign wr_word    = {cur_idx_ff, cur_sample_ff};

   // Expire a head whose index fell out of the current window.
   always_comb begin
      for (int k = 0; k < NUM_WEDGES; k++) begin
         drop[k] = (count_ff[k] != '0) &&
                   (LIM_W'(dist_of(cur_idx_ff, rd_word[k][WORD_W-1:SAMPLE_BITS])) > limit);
      end
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      in_idx_in     = in_idx_ff;
      out_idx_in    = out_idx_ff;
      cur_idx_in    = cur_idx_ff;
      cur_sample_in = cur_sample_ff;
      cur_last_in   = cur_last_ff;
      sel_max_in    = sel_max_ff;
      emitted_in    = emitted_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_max_in    = rsp_max_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_last_in   = rsp_last_ff;
      q_take        = 1'b0;
      wr_en         = '0;
      finish        = 1'b0;
      for (int k = 0; k < NUM_WEDGES; k++) begin
         wr_addr[k] = slot_of(head_ff[k], count_ff[k]);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take        = 1'b1;
               cur_sample_in = q_sample;
               cur_last_in   = q_ctrl.last;
               sel_max_in    = q_ctrl.rises;
               cur_idx_in    = in_idx_ff;
               in_idx_in     = idx_inc(in_idx_ff);
               emitted_in    = '0;
               if ((q_ctrl.rises ? count_ff[WEDGE_MAX] : count_ff[WEDGE_MIN]) != '0) begin
                  state_in = ST_POP;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_POP: begin
            // drop dominated tail entries of the selected wedge, one a cycle
            for (int k = 0; k < NUM_WEDGES; k++) begin
               if (((k == WEDGE_MAX) == sel_max_ff) && beats) begin
                  count_in[k] = count_ff[k] - CNT_W'(1);
               end
            end
            if (!beats || (sel_count == CNT_W'(1))) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            for (int k = 0; k < NUM_WEDGES; k++) begin
               wr_en[k] = 1'b1;
               if (count_ff[k] == CNT_W'(DEPTH)) begin
                  // full: the new entry overwrites the oldest
                  head_in[k] = slot_of(head_ff[k], CNT_W'(1));
               end else begin
                  count_in[k] = count_ff[k] + CNT_W'(1);
               end
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!cur_last_ff && (pend < w_idx)) begin
               finish = 1'b1;
            end else if (|drop) begin
               for (int k = 0; k < NUM_WEDGES; k++) begin
                  if (drop[k]) begin
                     head_in[k]  = slot_of(head_ff[k], CNT_W'(1));
                     count_in[k] = count_ff[k] - CNT_W'(1);
                  end
               end
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = (count_ff[WEDGE_MAX] != '0) ?
                              rd_word[WEDGE_MAX][SAMPLE_BITS-1:0] : '0;
               rsp_min_in   = (count_ff[WEDGE_MIN] != '0) ?
                              rd_word[WEDGE_MIN][SAMPLE_BITS-1:0] : '0;
               rsp_last_in  = cur_last_ff && (pend == '0);
               out_idx_in   = idx_inc(out_idx_ff);
               emitted_in   = emitted_ff + 1'b1;
               if ((pend == '0) || (emitted_ff == RESULT_CNT_W'(RESULT_LIMIT - 1))) begin
                  finish = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
         if (cur_last_ff) begin
            // end of stream: empty the wedges and restart the indices
            for (int k = 0; k < NUM_WEDGES; k++) begin
               head_in[k]  = '0;
               count_in[k] = '0;
            end
            in_idx_in  = '0;
            out_idx_in = '0;
         end
      end
   end

   // Read the tail while pruning, the head otherwise.
   always_comb begin
      for (int k = 0; k < NUM_WEDGES; k++) begin
         if ((state_in == ST_POP) && ((k == WEDGE_MAX) == sel_max_in)) begin
            rd_addr[k] = slot_of(head_in[k], count_in[k] - CNT_W'(1));
         end else begin
            rd_addr[k] = head_in[k];
         end
      end
   end

   for (genvar g = 0; g < NUM_WEDGES; g++) begin : g_wedge
      crmm_ram #(
         .WIDTH (WORD_W),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr[g]),
         .wr_data (wr_word),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_word[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int k = 0; k < NUM_WEDGES; k++) begin
            head_ff[k]  <= '0;
            count_ff[k] <= '0;
         end
         in_idx_ff    <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         in_idx_ff    <= in_idx_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff    <= cur_idx_in;
      cur_sample_ff <= cur_sample_in;
      cur_last_ff   <= cur_last_in;
      sel_max_ff    <= sel_max_in;
      emitted_ff    <= emitted_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_max     = rsp_max_ff;
   assign rsp_window_min     = rsp_min_ff;
   assign rsp_last_of_stream = rsp_last_ff;

endmodule

/* src/centered_running_min_max_unit.sv */
// Top level of the centered running min/max unit.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_stall    req_sample, req_end_of_stream
//   rsp      out        rsp_valid/rsp_stall    rsp_window_max, rsp_window_min,
//                                              rsp_last_of_stream
//   csr      in         csr_wr_en              csr_wr_data (half window)
//
// An item leaves the queue; then dominated tail entries of the selected wedge are
// removed one at a time until a tail compare stops pruning or the wedge empties;
// then the new entry is pushed; then come expiry steps and results, each result
// only while the result register is free, and a closing step unless its last
// result is for the newest index. The last item of a stream emits up to w+1
// results, one at a time, with any expiry steps between them. Each wedge RAM has
// one read port. Synchronous reset empties both wedges and sets the half window
// to 1; no clearing pass. Requests are taken while the two-entry queue has room;
// the result register holds its item under rsp_stall.
module centered_running_min_max_unit import crmm_pkg::*; #(
   parameter int MAX_HALF_WINDOW = 15,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_end_of_stream,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_max,
   output logic signed [SAMPLE_BITS-1:0] rsp_window_min,
   output logic                          rsp_last_of_stream,
   input  logic                          csr_wr_en,
   input  logic [HALF_WINDOW_W-1:0]      csr_wr_data
);

   logic [HALF_WINDOW_W-1:0]      half_window_ff, half_window_in;
   logic                          q_valid;
   logic                          q_take;
   logic signed [SAMPLE_BITS-1:0] q_sample;
   item_ctrl_type                 q_ctrl;

   assign half_window_in = csr_wr_en ? csr_wr_data : half_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff <= HALF_WINDOW_RESET;
      end else begin
         half_window_ff <= half_window_in;
      end
   end

   crmm_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_end_of_stream (req_end_of_stream),
      .q_valid           (q_valid),
      .q_take            (q_take),
      .q_sample          (q_sample),
      .q_ctrl            (q_ctrl)
   );

   crmm_back #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .half_window        (half_window_ff),
      .q_valid            (q_valid),
      .q_take             (q_take),
      .q_sample           (q_sample),
      .q_ctrl             (q_ctrl),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_max     (rsp_window_max),
      .rsp_window_min     (rsp_window_min),
      .rsp_last_of_stream (rsp_last_of_stream)
   );

endmodule

/* src/crmm_checker.sv */
// Port-level assertion checker for the centered running min/max unit, with its bind.
`include "assert_macros.svh"

module crmm_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_end_of_stream,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_window_max,
   input logic signed [SAMPLE_BITS-1:0] rsp_window_min,
   input logic                          rsp_last_of_stream
);

   logic [2:0] open_streams_ff, open_streams_in;
   logic       in_last;
   logic       out_last;

   assign in_last  = req_valid && !req_stall && req_end_of_stream;
   assign out_last = rsp_valid && !rsp_stall && rsp_last_of_stream;

   // Count streams ended at the input whose final result has not left yet.
   assign open_streams_in = open_streams_ff + 3'(in_last) - 3'(out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_streams_ff <= '0;
      end else begin
         open_streams_ff <= open_streams_in;
      end
   end

   `CRMM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_window_max) && $stable(rsp_window_min) && $stable(rsp_last_of_stream), "result item changed while stalled")
   `CRMM_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid && !req_stall, "unit not idle after reset")
   `CRMM_ASSERT(a_min_le_max, clock, reset, rsp_valid |-> rsp_window_min <= rsp_window_max, "window minimum above window maximum")
   `CRMM_ASSERT(a_last_follows_input, clock, reset, out_last |-> open_streams_ff != 3'd0, "end of stream result without an ended input stream")

endmodule

bind centered_running_min_max_unit crmm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_crmm_checker (.*);

/* bench/tb_centered_running_min_max_unit.sv */
// Self-checking bench for the centered running min/max unit, directed and random streams.
module tb_centered_running_min_max_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import crmm_pkg::*;

   localparam int SAMPLE_W       = 16;
   localparam int MAX_HW         = 15;
   localparam int WEDGE_DEPTH    = 2 * MAX_HW + 2;
   localparam int SETTLE_CYCLES  = 160;
   localparam int RX_HOLD_CYCLES = 400;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [5:0] pos_type;

   typedef struct {
      sample_type value;
      logic       last;
   } sample_item_type;

   typedef struct {
      sample_type hi;
      sample_type lo;
      logic       last;
   } window_extremes_type;

   typedef enum {SHAPE_WIDE, SHAPE_NARROW, SHAPE_RISING, SHAPE_FALLING, SHAPE_RAILS}
      stream_shape_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   sample_type               req_sample = '0;
   logic                     req_end_of_stream = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   sample_type               rsp_window_max;
   sample_type               rsp_window_min;
   logic                     rsp_last_of_stream;
   logic                     csr_wr_en = 1'b0;
   logic [HALF_WINDOW_W-1:0] csr_wr_data = '0;

   // predictor state: candidate wedges, stream positions, current half window
   sample_type wedge_val [NUM_WEDGES][WEDGE_DEPTH];
   pos_type    wedge_pos [NUM_WEDGES][WEDGE_DEPTH];
   int         wedge_head [NUM_WEDGES];
   int         wedge_cnt [NUM_WEDGES];
   pos_type    next_in_pos;
   pos_type    next_out_pos;
   sample_type last_sample;
   int         half_window_cur;

   window_extremes_type expected_windows[$];
   window_extremes_type want;
   sample_item_type     pending_samples[$];
   sample_item_type     on_port;

   int  items_queued = 0;
   int  items_accepted = 0;
   int  results_seen = 0;
   int  streams_closed = 0;
   int  config_writes = 0;
   int  failures = 0;
   int  tx_wait = 0;
   int  rx_wait = 0;
   int  rx_hold_left = 0;
   int  hold_served = 0;
   int  hold_requests = 0;
   bit  quiet = 1'b0;

   centered_running_min_max_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_end_of_stream  (req_end_of_stream),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_max     (rsp_window_max),
      .rsp_window_min     (rsp_window_min),
      .rsp_last_of_stream (rsp_last_of_stream),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial forever #4 clock = ~clock;

   task automatic note_failure(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      failures++;
   endtask

   function automatic void clear_windows();
      for (int q = 0; q < NUM_WEDGES; q++) begin
         wedge_head[q] = 0;
         wedge_cnt[q] = 0;
      end
      next_in_pos = '0;
      next_out_pos = '0;
      last_sample = '0;
   endfunction

   function automatic void drop_oldest(int q);
      if (wedge_cnt[q] > 0) begin
         wedge_head[q] = (wedge_head[q] + 1) % WEDGE_DEPTH;
         wedge_cnt[q]--;
      end
   endfunction

   function automatic void append(int q, sample_type v, pos_type p);
      int s;
      if (wedge_cnt[q] >= WEDGE_DEPTH) drop_oldest(q);
      s = (wedge_head[q] + wedge_cnt[q]) % WEDGE_DEPTH;
      wedge_val[q][s] = v;
      wedge_pos[q][s] = p;
      wedge_cnt[q]++;
   endfunction

   // drop tail entries that the new sample dominates; equal values stay
   function automatic void prune_tail(int q, sample_type v);
      sample_type t;
      while (wedge_cnt[q] > 0) begin
         t = wedge_val[q][(wedge_head[q] + wedge_cnt[q] - 1) % WEDGE_DEPTH];
         if ((q == WEDGE_MAX) ? (v > t) : (v < t)) wedge_cnt[q]--;
         else break;
      end
   endfunction

   function automatic pos_type pos_gap(pos_type newer, pos_type older);
      return newer - older;
   endfunction

   function automatic void expire_heads(int q, pos_type now, int reach);
      while (wedge_cnt[q] > 0 && int'(pos_gap(now, wedge_pos[q][wedge_head[q]])) > reach)
         drop_oldest(q);
   endfunction

   function automatic void advance_window(sample_item_type it);
      pos_type now;
      pos_type pend;
      int n;
      window_extremes_type r;
      now = next_in_pos;
      n = 0;
      if (wedge_cnt[WEDGE_MAX] > 0 || wedge_cnt[WEDGE_MIN] > 0) begin
         if (it.value > last_sample) prune_tail(WEDGE_MAX, it.value);
         else prune_tail(WEDGE_MIN, it.value);
      end
      append(WEDGE_MAX, it.value, now);
      append(WEDGE_MIN, it.value, now);
      last_sample = it.value;
      next_in_pos = now + 6'd1;
      while (n < RESULT_LIMIT) begin
         pend = pos_gap(now, next_out_pos);
         if (!it.last && int'(pend) < half_window_cur) break;
         expire_heads(WEDGE_MAX, now, int'(pend) + half_window_cur);
         expire_heads(WEDGE_MIN, now, int'(pend) + half_window_cur);
         r.hi = wedge_cnt[WEDGE_MAX] > 0 ? wedge_val[WEDGE_MAX][wedge_head[WEDGE_MAX]] : '0;
         r.lo = wedge_cnt[WEDGE_MIN] > 0 ? wedge_val[WEDGE_MIN][wedge_head[WEDGE_MIN]] : '0;
         r.last = it.last && pend == 0;
         expected_windows.push_back(r);
         n++;
         next_out_pos = next_out_pos + 6'd1;
         if (pend == 0) break;
      end
      if (it.last) clear_windows();
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 45);
   endfunction

   function automatic sample_type draw_sample(stream_shape_type shape, int k);
      int r;
      case (shape)
         SHAPE_NARROW:  return sample_type'(int'($urandom_range(6)) - 3);
         SHAPE_RISING:  return sample_type'(k * 700 - 20000 + int'($urandom_range(300)));
         SHAPE_FALLING: return sample_type'(20000 - k * 700 - int'($urandom_range(300)));
         SHAPE_RAILS: begin
            r = $urandom_range(2);
            if (r == 0) return 16'sh7FFF;
            if (r == 1) return 16'sh8000;
            return '0;
         end
         default:       return sample_type'($urandom);
      endcase
   endfunction

   task automatic queue_item(input sample_type v, input logic last);
      sample_item_type it;
      it.value = v;
      it.last = last;
      pending_samples.push_back(it);
      items_queued++;
      if (last) streams_closed++;
   endtask

   task automatic queue_stream(input int len, input stream_shape_type shape, input bit close);
      for (int k = 0; k < len; k++)
         queue_item(draw_sample(shape, k), close && (k == len - 1));
   endtask

   // back-to-back streams of random shape; the last one may stay open
   task automatic queue_random(input int total, input int max_len);
      int len;
      bit close;
      while (total > 0) begin
         len = $urandom_range(1, max_len);
         close = 1'b1;
         if (len >= total) begin
            len = total;
            close = $urandom_range(1);
         end
         queue_stream(len, stream_shape_type'($urandom_range(4)), close);
         total -= len;
      end
   endtask

   // hold new items until everything queued is taken and every result is back
   task automatic settle();
      while (items_accepted != items_queued || expected_windows.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_half_window(input int v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= HALF_WINDOW_W'(v);
      half_window_cur = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      config_writes++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_window(on_port);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               on_port = pending_samples.pop_front();
               req_sample <= on_port.value;
               req_end_of_stream <= on_port.last;
               req_valid <= 1'b1;
               tx_wait = quiet ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure, with an occasional long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         rx_hold_left = RX_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rx_wait = pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_windows.size() == 0) begin
            note_failure($sformatf("unexpected result max %0d min %0d last %0b",
                                   rsp_window_max, rsp_window_min, rsp_last_of_stream));
         end else begin
            want = expected_windows.pop_front();
            if (rsp_window_max !== want.hi)
               note_failure($sformatf("result %0d window_max got %0d expected %0d",
                                      results_seen, rsp_window_max, want.hi));
            if (rsp_window_min !== want.lo)
               note_failure($sformatf("result %0d window_min got %0d expected %0d",
                                      results_seen, rsp_window_min, want.lo));
            if (rsp_last_of_stream !== want.last)
               note_failure($sformatf("result %0d last_of_stream got %b expected %b",
                                      results_seen, rsp_last_of_stream, want.last));
         end
      end
   end

   initial begin
      clear_windows();
      half_window_cur = int'(HALF_WINDOW_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset half window: single-sample stream, rails, equal run
      queue_item(16'sh7FFF, 1'b1);
      queue_item(16'sh8000, 1'b0);
      queue_item(16'sh7FFF, 1'b1);
      queue_item(5, 1'b0);
      queue_item(5, 1'b0);
      queue_item(5, 1'b1);
      settle();
      set_half_window(0);
      queue_item(16'sh8000, 1'b0);
      queue_item(0, 1'b0);
      queue_item(16'sh7FFF, 1'b1);
      settle();
      // widest window: a stream shorter than the half width
      set_half_window(MAX_HW);
      queue_item(100, 1'b0);
      queue_item(-100, 1'b0);
      queue_item(100, 1'b0);
      queue_item(-100, 1'b1);
      for (int k = 0; k < 5; k++) queue_item(sample_type'(k * 1000 - 2000), 1'b0);
      settle();
      // shrink mid-stream: the pending indexes leave at once
      set_half_window(0);
      queue_item(-7, 1'b0);
      queue_item(9, 1'b1);
      queue_item(-1, 1'b0);
      queue_item(1, 1'b0);
      settle();
      // grow mid-stream
      set_half_window(3);
      queue_item(2, 1'b0);
      queue_item(16'sh8000, 1'b0);
      queue_item(16'sh7FFF, 1'b1);
      settle();

      // long receiver hold-off while the sender keeps offering
      set_half_window(2);
      hold_requests <= hold_requests + 1;
      queue_random(20, 8);
      settle();
      // one stream past the index wrap
      set_half_window(MAX_HW);
      queue_stream(66, SHAPE_WIDE, 1'b1);
      settle();
      quiet <= 1'b1;
      set_half_window(5);
      queue_random(10, 14);
      settle();
      quiet <= 1'b0;
      set_half_window(1);
      queue_random(10, 5);
      settle();
      set_half_window(0);
      queue_random(8, 6);
      settle();
      set_half_window(11);
      queue_random(12, 30);
      settle();
      set_half_window(MAX_HW);
      queue_random(10, 20);
      settle();

      $display("Run covered %0d samples in %0d closed streams, %0d windows checked, %0d %s",
               items_accepted, streams_closed, results_seen, config_writes,
               "half-window writes");
      $display("Half widths 0 to 15, mid-stream shrink and growth, index wrap, long hold-off.");
      if (failures == 0) begin
         $display("centered_running_min_max_unit verification clean");
      end else begin
         $display("centered_running_min_max_unit verification failed");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timeout with %0d windows still outstanding", expected_windows.size());
      $display("centered_running_min_max_unit verification failed");
      $finish;
   end

endmodule
